// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the prefix decoder RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define AM_ASSERT_SAME(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// Condition c must hold in the cycle after a.
`define AM_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// ===== hdl/xpd_pkg.sv =====
// Package for the x86 prefix decoder: widths, codes, types and decode functions.
// No dependencies.
package xpd_pkg;

    localparam int ByteW    = 8;
    localparam int SegW     = 3;
    localparam int RepW     = 2;
    localparam int CpuW     = 3;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 3;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgCpuModel = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgSsBig    = 2'd1;

    localparam logic [CpuW-1:0] Cpu80286 = 3'd2;

    // Prefix bytes
    localparam logic [ByteW-1:0] PfxRepne = 8'hF2;
    localparam logic [ByteW-1:0] PfxRep   = 8'hF3;
    localparam logic [ByteW-1:0] PfxLock  = 8'hF0;
    localparam logic [ByteW-1:0] PfxCs    = 8'h2E;
    localparam logic [ByteW-1:0] PfxSs    = 8'h36;
    localparam logic [ByteW-1:0] PfxDs    = 8'h3E;
    localparam logic [ByteW-1:0] PfxEs    = 8'h26;
    localparam logic [ByteW-1:0] PfxFs    = 8'h64;
    localparam logic [ByteW-1:0] PfxGs    = 8'h65;
    localparam logic [ByteW-1:0] PfxOpsz  = 8'h66;
    localparam logic [ByteW-1:0] PfxAdsz  = 8'h67;

    typedef enum logic [SegW-1:0] {
        SEG_CS   = 3'd0,
        SEG_SS   = 3'd1,
        SEG_DS   = 3'd2,
        SEG_ES   = 3'd3,
        SEG_FS   = 3'd4,
        SEG_GS   = 3'd5,
        SEG_NONE = 3'd6
    } t_seg;

    typedef enum logic [RepW-1:0] {
        REP_NONE     = 2'd0,
        REP_PLAIN    = 2'd1,
        REP_WHILE_Z  = 2'd2,
        REP_WHILE_NZ = 2'd3
    } t_rep_mode;

    typedef enum logic [1:0] {
        STR_NONE = 2'd0,
        STR_MOVE = 2'd1,
        STR_CMP  = 2'd2
    } t_str_kind;

    // Prefix state gathered for the instruction in flight
    typedef struct packed {
        logic repne;
        logic rep;
        logic lock;
        logic opsz;
        logic adsz;
        t_seg seg;
    } t_pfx_state;

    localparam t_pfx_state PfxClear = '{repne: 1'b0, rep: 1'b0, lock: 1'b0,
                                        opsz: 1'b0, adsz: 1'b0, seg: SEG_NONE};

    function automatic logic is_prefix(input logic [ByteW-1:0] b);
        return (b == PfxRepne) || (b == PfxRep) || (b == PfxLock) ||
               (b == PfxCs) || (b == PfxSs) || (b == PfxDs) || (b == PfxEs) ||
               (b == PfxFs) || (b == PfxGs) || (b == PfxOpsz) || (b == PfxAdsz);
    endfunction

    // Fold one prefix byte into the state; a later segment override wins.
    function automatic t_pfx_state add_prefix(input t_pfx_state s,
                                              input logic [ByteW-1:0] b);
        t_pfx_state r;
        r = s;
        unique case (b)
            PfxRepne: r.repne = 1'b1;
            PfxRep:   r.rep   = 1'b1;
            PfxLock:  r.lock  = 1'b1;
            PfxCs:    r.seg   = SEG_CS;
            PfxSs:    r.seg   = SEG_SS;
            PfxDs:    r.seg   = SEG_DS;
            PfxEs:    r.seg   = SEG_ES;
            PfxFs:    r.seg   = SEG_FS;
            PfxGs:    r.seg   = SEG_GS;
            PfxOpsz:  r.opsz  = 1'b1;
            PfxAdsz:  r.adsz  = 1'b1;
            default:  r = s;
        endcase
        return r;
    endfunction

    function automatic t_str_kind str_kind(input logic [ByteW-1:0] op);
        t_str_kind k;
        unique case (op)
            8'hA4, 8'hA5, 8'hAA, 8'hAB, 8'hAC, 8'hAD: k = STR_MOVE;
            8'hA6, 8'hA7, 8'hAE, 8'hAF:               k = STR_CMP;
            default:                                  k = STR_NONE;
        endcase
        return k;
    endfunction

    // F2 takes precedence over F3
    function automatic t_rep_mode rep_class(input t_pfx_state s,
                                            input logic [ByteW-1:0] op);
        t_str_kind k;
        t_rep_mode m;
        k = str_kind(op);
        m = REP_NONE;
        priority if (s.repne) begin
            if (k == STR_MOVE)     m = REP_PLAIN;
            else if (k == STR_CMP) m = REP_WHILE_NZ;
        end else if (s.rep) begin
            if (k == STR_MOVE)     m = REP_PLAIN;
            else if (k == STR_CMP) m = REP_WHILE_Z;
        end else begin
            m = REP_NONE;
        end
        return m;
    endfunction

endpackage

// ===== hdl/xpd_ifs.sv =====
// Channel interfaces for the x86 prefix decoder: byte, result and config write.
// Depends on xpd_pkg.
interface xpd_byte_if import xpd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

interface xpd_result_if import xpd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] opcode;
    logic [SegW-1:0]  segment_override;
    logic             lock_seen;
    logic [RepW-1:0]  rep_mode;
    logic             stack_address_32;
    logic             operand_32;
    logic             address_32;

    modport source (output valid, output opcode, output segment_override,
                    output lock_seen, output rep_mode, output stack_address_32,
                    output operand_32, output address_32, input ready);
    modport sink   (input valid, input opcode, input segment_override,
                    input lock_seen, input rep_mode, input stack_address_32,
                    input operand_32, input address_32, output ready);
endinterface

interface xpd_cfg_if import xpd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/x86_prefix_decoder_top.sv =====
// The result word of an accepted non-prefix byte is registered and held on the output.
// Throughput: one byte per cycle while ready is high; a prefix byte yields no word, an opcode byte yields one.
// Ready drops only while a result word is held and the sink is not taking it.
// Reset (i_rst_n, synchronous, active low) clears the prefix state, the output valid
// and the configuration registers (cpu model 8086, stack segment not big).
// Depends on xpd_pkg, xpd_ifs and assert_macros.svh.
`include "assert_macros.svh"

module x86_prefix_decoder_top import xpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xpd_cfg_if.sink     i_cfg,
    xpd_byte_if.sink    i_byte,
    xpd_result_if.source o_insn
);

    // Configuration registers
    logic [CpuW-1:0] r_cpu_model;
    logic            r_ss_big;

    // Prefix state for the instruction being gathered
    t_pfx_state r_pfx, n_pfx;

    // Result word register
    logic             r_out_valid, n_out_valid;
    logic [ByteW-1:0] r_opcode, n_opcode;
    t_seg             r_seg, n_seg;
    logic             r_lock, n_lock;
    t_rep_mode        r_rep, n_rep;
    logic             r_stk32, n_stk32;
    logic             r_op32, n_op32;
    logic             r_ad32, n_ad32;

    logic byte_acc;
    logic byte_pfx;
    logic stk32;

    // Config writes are taken at once; writes beyond the list are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_model <= '0;
            r_ss_big    <= 1'b0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CfgCpuModel) r_cpu_model <= i_cfg.data[CpuW-1:0];
            if (i_cfg.index == CfgSsBig)    r_ss_big    <= i_cfg.data[0];
        end
    end

    // Accept a byte whenever the result slot is free or being drained this cycle.
    assign i_byte.ready = !r_out_valid || o_insn.ready;
    assign byte_acc     = i_byte.valid && i_byte.ready;
    assign byte_pfx     = is_prefix(i_byte.code_byte);

    // Stack size follows the SS big bit from the 286 onwards (out-of-range models too).
    assign stk32 = (r_cpu_model >= Cpu80286) && r_ss_big;

    always_comb begin
        n_pfx       = r_pfx;
        n_out_valid = r_out_valid && !o_insn.ready;
        n_opcode    = r_opcode;
        n_seg       = r_seg;
        n_lock      = r_lock;
        n_rep       = r_rep;
        n_stk32     = r_stk32;
        n_op32      = r_op32;
        n_ad32      = r_ad32;
        if (byte_acc) begin
            if (byte_pfx) begin
                // fold the prefix in, no word yet
                n_pfx = add_prefix(r_pfx, i_byte.code_byte);
            end else begin
                // opcode: emit the word and start afresh for the next instruction
                n_out_valid = 1'b1;
                n_opcode    = i_byte.code_byte;
                n_seg       = r_pfx.seg;
                n_lock      = r_pfx.lock;
                n_rep       = rep_class(r_pfx, i_byte.code_byte);
                n_stk32     = stk32;
                n_op32      = stk32 ^ r_pfx.opsz;
                n_ad32      = stk32 ^ r_pfx.adsz;
                n_pfx       = PfxClear;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfx       <= PfxClear;
            r_out_valid <= 1'b0;
        end else begin
            r_pfx       <= n_pfx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_opcode <= n_opcode;
        r_seg    <= n_seg;
        r_lock   <= n_lock;
        r_rep    <= n_rep;
        r_stk32  <= n_stk32;
        r_op32   <= n_op32;
        r_ad32   <= n_ad32;
    end

    assign o_insn.valid            = r_out_valid;
    assign o_insn.opcode           = r_opcode;
    assign o_insn.segment_override = SegW'(r_seg);
    assign o_insn.lock_seen        = r_lock;
    assign o_insn.rep_mode         = RepW'(r_rep);
    assign o_insn.stack_address_32 = r_stk32;
    assign o_insn.operand_32       = r_op32;
    assign o_insn.address_32       = r_ad32;

    // An opcode byte yields its word on the next cycle.
    `AM_ASSERT_NEXT(a_opcode_emits, i_clk, i_rst_n, byte_acc && !byte_pfx,
        r_out_valid && (r_opcode == $past(i_byte.code_byte)) && (r_pfx == PfxClear))
    // A prefix byte never raises valid.
    `AM_ASSERT_NEXT(a_prefix_silent, i_clk, i_rst_n, byte_acc && byte_pfx && !r_out_valid,
        !r_out_valid)
    // A repeat mode is only given to string opcodes, all of which lie in A0..AF.
    `AM_ASSERT_SAME(a_rep_on_string, i_clk, i_rst_n, r_out_valid && (r_rep != REP_NONE),
        r_opcode[7:4] == 4'hA)
    // The segment code of a held word is a segment or the no-override code.
    `AM_ASSERT_SAME(a_seg_code, i_clk, i_rst_n, r_out_valid,
        r_seg <= SEG_NONE)

endmodule

// ===== verif/x86_prefix_decoder_top_tb.sv =====
// Self-checking testbench for x86_prefix_decoder_top: prefix runs, opcodes and CPU settings.
// Depends on xpd_pkg, the channel interfaces in xpd_ifs and the decoder RTL.
`timescale 1ns / 100ps

module x86_prefix_decoder_top_tb;
    import xpd_pkg::*;

    localparam int WatchdogNs    = 2_000_000;
    localparam int DrainCycles   = 4;       // extra cycles after the queue empties
    localparam int HoldoffCycles = 300;
    localparam int EndLimit      = 10_000;

    // String opcodes that the REP classification cares about
    localparam logic [ByteW-1:0] OpMovsb = 8'hA4;
    localparam logic [ByteW-1:0] OpMovsw = 8'hA5;
    localparam logic [ByteW-1:0] OpCmpsb = 8'hA6;
    localparam logic [ByteW-1:0] OpCmpsw = 8'hA7;
    localparam logic [ByteW-1:0] OpStosb = 8'hAA;
    localparam logic [ByteW-1:0] OpStosw = 8'hAB;
    localparam logic [ByteW-1:0] OpLodsb = 8'hAC;
    localparam logic [ByteW-1:0] OpLodsw = 8'hAD;
    localparam logic [ByteW-1:0] OpScasb = 8'hAE;
    localparam logic [ByteW-1:0] OpScasw = 8'hAF;
    localparam logic [ByteW-1:0] OpNop   = 8'h90;

    // One decoded instruction word as the block should present it
    typedef struct packed {
        logic [ByteW-1:0] opcode;
        t_seg             seg;
        logic             lock;
        t_rep_mode        rep;
        logic             stack32;
        logic             oper32;
        logic             addr32;
    } t_insn_word;

    // Prefix state gathered by the predictor for the instruction in flight
    typedef struct {
        logic repne;
        logic rep;
        logic lock;
        logic opsz;
        logic adsz;
        t_seg seg;
    } t_prefix_track;

    logic i_clk = 1'b0;
    logic i_rst_n;

    xpd_cfg_if    cfg_ch ();
    xpd_byte_if   byte_ch ();
    xpd_result_if insn_ch ();

    x86_prefix_decoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_byte  (byte_ch),
        .o_insn  (insn_ch)
    );

    always #2 i_clk = ~i_clk;

    // Predictor copy of the configuration and the prefix state
    logic [CpuW-1:0] model_cpu    = '0;
    logic            model_ss_big = 1'b0;
    t_prefix_track   pfx          = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEG_NONE};

    t_insn_word pending_insns[$];

    int errors        = 0;
    int bytes_sent    = 0;
    int words_checked = 0;
    int settings_used = 0;

    // Sender burst control
    bit gaps_on    = 1'b1;
    int burst_left = 0;

    // Receiver stall control; the hold-off request is a sequence number
    int          holdoff_req  = 0;
    int          holdoff_seen = 0;
    int          holdoff_left = 0;
    int          epoch_cnt    = 0;
    logic [15:0] stall_pattern = 16'hFFFF;

    // ------------------------------------------------------------------
    // Predictor: fold one accepted byte into the prefix state, or close
    // the instruction and queue the word that it must produce.
    // ------------------------------------------------------------------
    task automatic absorb_byte(input logic [ByteW-1:0] b);
        t_insn_word w;
        logic       stk;
        case (b)
            PfxRepne: pfx.repne = 1'b1;
            PfxRep:   pfx.rep   = 1'b1;
            PfxLock:  pfx.lock  = 1'b1;
            PfxCs:    pfx.seg   = SEG_CS;
            PfxSs:    pfx.seg   = SEG_SS;
            PfxDs:    pfx.seg   = SEG_DS;
            PfxEs:    pfx.seg   = SEG_ES;
            PfxFs:    pfx.seg   = SEG_FS;
            PfxGs:    pfx.seg   = SEG_GS;
            PfxOpsz:  pfx.opsz  = 1'b1;
            PfxAdsz:  pfx.adsz  = 1'b1;
            default: begin
                // Stack size comes from the SS big bit on 286 and later,
                // including the undefined models above 486.
                stk = (model_cpu >= Cpu80286) ? model_ss_big : 1'b0;
                w.opcode  = b;
                w.seg     = pfx.seg;
                w.lock    = pfx.lock;
                w.stack32 = stk;
                w.oper32  = stk ^ pfx.opsz;
                w.addr32  = stk ^ pfx.adsz;
                w.rep     = REP_NONE;
                // REPNE wins over REP when both are present
                if (pfx.repne || pfx.rep) begin
                    case (b)
                        OpMovsb, OpMovsw, OpStosb, OpStosw, OpLodsb, OpLodsw:
                            w.rep = REP_PLAIN;
                        OpCmpsb, OpCmpsw, OpScasb, OpScasw:
                            w.rep = pfx.repne ? REP_WHILE_NZ : REP_WHILE_Z;
                        default: w.rep = REP_NONE;
                    endcase
                end
                pending_insns.push_back(w);
                // Clear the prefix state for the next instruction
                pfx = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SEG_NONE};
            end
        endcase
    endtask

    // Watch the byte channel: every accepted byte goes through the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && byte_ch.valid && byte_ch.ready)
            absorb_byte(byte_ch.code_byte);
    end

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    // Compare every accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_insn_word w;
        if (i_rst_n && insn_ch.valid && insn_ch.ready) begin
            if (pending_insns.size() == 0) begin
                $error("unexpected instruction word, opcode %0h", insn_ch.opcode);
                errors++;
            end else begin
                w = pending_insns.pop_front();
                words_checked++;
                check_field("opcode", w.opcode, insn_ch.opcode);
                check_field("segment_override", 8'(w.seg), 8'(insn_ch.segment_override));
                check_field("lock_seen", 8'(w.lock), 8'(insn_ch.lock_seen));
                check_field("rep_mode", 8'(w.rep), 8'(insn_ch.rep_mode));
                check_field("stack_address_32", 8'(w.stack32),
                            8'(insn_ch.stack_address_32));
                check_field("operand_32", 8'(w.oper32), 8'(insn_ch.operand_32));
                check_field("address_32", 8'(w.addr32), 8'(insn_ch.address_32));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a rotating pattern refreshed whenever epoch_cnt wraps;
    // on request, hold off for a long stretch so the block fills up.
    // ------------------------------------------------------------------
    initial insn_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        if (holdoff_seen != holdoff_req) begin
            holdoff_seen = holdoff_req;
            holdoff_left = HoldoffCycles;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            insn_ch.ready <= 1'b0;
        end else begin
            epoch_cnt++;
            if (epoch_cnt == 64) begin
                epoch_cnt = 0;
                case ($urandom_range(0, 3))
                    0: stall_pattern = 16'hFFFF;                        // no stalls
                    1: stall_pattern = 16'($urandom);
                    2: stall_pattern = 16'($urandom) | 16'($urandom);   // light
                    default: stall_pattern = 16'($urandom) & 16'($urandom); // heavy
                endcase
            end
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            insn_ch.ready <= stall_pattern[0];
        end
    end

    // ------------------------------------------------------------------
    // Sender: offer one byte and hold it until taken. Bursts of random
    // length end in a random gap; valid stays high inside a burst.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [ByteW-1:0] b);
        int gap;
        byte_ch.valid     <= 1'b1;
        byte_ch.code_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        bytes_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(0, 12);
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // One instruction: a prefix run (now and then a long one), then an opcode
    // that is never a prefix, biased towards the string instructions.
    task automatic send_insn(input int max_pfx);
        int               n;
        logic [ByteW-1:0] p;
        logic [ByteW-1:0] op;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 30)
                                         : $urandom_range(0, max_pfx);
        repeat (n) begin
            case ($urandom_range(0, 10))
                0: p = PfxRepne;
                1: p = PfxRep;
                2: p = PfxLock;
                3: p = PfxCs;
                4: p = PfxSs;
                5: p = PfxDs;
                6: p = PfxEs;
                7: p = PfxFs;
                8: p = PfxGs;
                9: p = PfxOpsz;
                default: p = PfxAdsz;
            endcase
            send_byte(p);
        end
        if ($urandom_range(0, 9) < 4) begin
            case ($urandom_range(0, 9))
                0: op = OpMovsb;
                1: op = OpMovsw;
                2: op = OpCmpsb;
                3: op = OpCmpsw;
                4: op = OpStosb;
                5: op = OpStosw;
                6: op = OpLodsb;
                7: op = OpLodsw;
                8: op = OpScasb;
                default: op = OpScasw;
            endcase
        end else begin
            do op = 8'($urandom);
            while (op inside {PfxRepne, PfxRep, PfxLock, PfxCs, PfxSs, PfxDs,
                              PfxEs, PfxFs, PfxGs, PfxOpsz, PfxAdsz});
        end
        send_byte(op);
    endtask

    // Drop valid and hold until every expected word has arrived; wait for the
    // coming edge first so the byte taken at that edge has reached the predictor.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_insns.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                             input logic [CfgDataW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle
    task automatic set_config(input logic [CpuW-1:0] cpu, input logic big);
        wait_drained();
        write_reg(CfgCpuModel, CfgDataW'(cpu));
        model_cpu = cpu;
        write_reg(CfgSsBig, CfgDataW'(big));
        model_ss_big = big;
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes, REP classes and precedence, every prefix, repeats and the
    // last segment override winning, all under the reset configuration.
    task automatic test_directed();
        logic [ByteW-1:0] seq[$];
        seq = '{8'h00, 8'hFF,
                PfxRepne, OpCmpsb,
                PfxRep, OpCmpsb,
                PfxRep, PfxRepne, OpScasb,
                PfxRepne, OpMovsb,
                PfxRep, OpNop,
                PfxLock, PfxLock, PfxCs, PfxSs, PfxDs, PfxEs, PfxFs, PfxGs,
                PfxOpsz, PfxAdsz, OpMovsw};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // Every CPU model, the undefined ones included, with both SS sizes
    task automatic test_config_sweep();
        for (int cpu = 0; cpu < 8; cpu++) begin
            for (int big = 0; big < 2; big++) begin
                set_config(cpu[CpuW-1:0], big[0]);
                repeat (3) send_insn(3);
            end
        end
    endtask

    // Mostly well-formed instructions with some raw bytes mixed in,
    // across random settings with and without sender gaps
    task automatic test_random();
        int start;
        repeat (6) begin
            set_config(CpuW'($urandom_range(0, 7)), 1'($urandom));
            gaps_on = ($urandom_range(0, 3) != 0);
            start   = bytes_sent;
            while (bytes_sent - start < 70) begin
                if ($urandom_range(0, 9) == 0)
                    send_byte(8'($urandom));
                else
                    send_insn(4);
            end
            // Close any prefix run left by raw bytes before the next setting
            send_insn(0);
        end
        gaps_on = 1'b1;
    endtask

    // Hold the receiver off while the sender keeps offering back to back
    task automatic test_backpressure();
        set_config(CpuW'(3), 1'b1);
        gaps_on = 1'b0;
        holdoff_req <= holdoff_req + 1;
        repeat (30) send_insn(1);
        gaps_on = 1'b1;
    endtask

    // Pause the sender until everything has drained, then carry on
    task automatic test_drain_pause();
        set_config(CpuW'(4), 1'b0);
        repeat (10) send_insn(2);
        wait_drained();
        repeat (10) send_insn(2);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int guard;
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.code_byte = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CfgCpuModel;
        cfg_ch.data       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        test_random();
        test_backpressure();
        test_drain_pause();

        // Drain what is left, with a limit, then let the pipe settle
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending_insns.size() != 0 && guard < EndLimit) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_insns.size() != 0) begin
            $error("%0d instruction words never arrived", pending_insns.size());
            errors++;
        end

        $display("Sent %0d code bytes, checked %0d instruction words over %0d settings",
                 bytes_sent, words_checked, settings_used);
        $display("Covered every prefix, REP classes, CPU models 0-7 and long stalls");
        if (errors == 0) begin
            $display("PASS x86_prefix_decoder_top");
        end else begin
            $display("FAIL x86_prefix_decoder_top");
        end
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #WatchdogNs;
        $display("FAIL x86_prefix_decoder_top");
        $finish;
    end

endmodule
